// ===== hw/rtl/grid_maze_dfs_carver_top_macros.svh =====
// Assertion macros shared by the maze carver RTL.
`ifndef GRID_MAZE_DFS_CARVER_TOP_MACROS_SVH
`define GRID_MAZE_DFS_CARVER_TOP_MACROS_SVH

// Check a property on every rising edge, off while reset is asserted.
`define GMDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define GMDC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/gmdc_pkg.sv =====
// Shared types and constants of the maze carver.
package gmdc_pkg;

  // Field widths of the channels and registers
  localparam int unsigned CMD_W      = 1;
  localparam int unsigned EVENT_W    = 2;
  localparam int unsigned CELL_X_W   = 8;
  localparam int unsigned CELL_Y_W   = 7;
  localparam int unsigned DIR_W      = 2;
  localparam int unsigned DEPTH_W    = 15;
  localparam int unsigned LAST_COL_W = 8;
  localparam int unsigned LAST_ROW_W = 7;
  localparam int unsigned WALL_W     = 4;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  // Register reset values
  localparam logic [LAST_COL_W-1:0] LAST_COL_RST = 8'd21;
  localparam logic [LAST_ROW_W-1:0] LAST_ROW_RST = 7'd21;

  // Register indexes (paddr[2])
  localparam logic REG_LAST_COLUMN = 1'b0;
  localparam logic REG_LAST_ROW    = 1'b1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_START = 1'b0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 1'b1;

  // Result events
  localparam logic [EVENT_W-1:0] EV_ENTER = 2'd0;
  localparam logic [EVENT_W-1:0] EV_BACK  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DONE  = 2'd2;

  // Directions
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;
  localparam logic [DIR_W-1:0] DIR_FLIP  = 2'd2;

  localparam logic [WALL_W-1:0] WALL_ALL  = 4'hF;
  localparam logic [WALL_W-1:0] WALL_NONE = 4'h0;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_PROBE,
    ST_DECIDE,
    ST_WR_NB,
    ST_EMIT
  } state_e;

  // One result word
  typedef struct packed {
    logic [EVENT_W-1:0]  event_res;
    logic [CELL_X_W-1:0] cell_x;
    logic [CELL_Y_W-1:0] cell_y;
    logic [DIR_W-1:0]    entry_dir;
    logic [DEPTH_W-1:0]  depth;
  } res_t;

endpackage

// ===== hw/rtl/gmdc_in_if.sv =====
// Command channel of the maze carver.
interface gmdc_in_if #(
  parameter int unsigned DRAWS_PER_STEP = 5
);
  import gmdc_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [CMD_W-1:0]              cmd;
  logic [2*DRAWS_PER_STEP-1:0]   random_draws;

  modport source (output valid, cmd, random_draws, input ready);
  modport sink   (input valid, cmd, random_draws, output ready);
endinterface

// ===== hw/rtl/gmdc_out_if.sv =====
// Result channel of the maze carver.
interface gmdc_out_if;
  import gmdc_pkg::*;

  logic                valid;
  logic                ready;
  logic [EVENT_W-1:0]  event_res;
  logic [CELL_X_W-1:0] cell_x;
  logic [CELL_Y_W-1:0] cell_y;
  logic [DIR_W-1:0]    entry_dir;
  logic [DEPTH_W-1:0]  depth;

  modport source (output valid, event_res, cell_x, cell_y, entry_dir, depth, input ready);
  modport sink   (input valid, event_res, cell_x, cell_y, entry_dir, depth, output ready);
endinterface

// ===== hw/rtl/grid_maze_dfs_carver_top.sv =====
// Depth-first maze carver: wall memory, path stack and step sequencer.
// Usage: the command channel in_i takes one word per command (start or carve
// step, with the random draws); each command gives exactly one result word on
// out_o. Registers last_column (0x0) and last_row (0x4) are to be written over
// APB only while the block is idle; the block itself does not enforce this.
// Sequence: a start sweeps the whole wall memory, one cell per cycle, then
// loads its result. A carve step that enters a cell does one stack read, five
// wall reads and a settle slot on the single wall memory read port, then a
// decide step that writes the top cell, a step that writes the neighbor and
// pushes it, and a step that loads the result register. A backtrack skips the
// neighbor write. A step on an empty stack goes straight to the result.
// in_i.ready is high only while the sequencer is idle.
// Reset: the stack is empty and the registers hold 21; a step before any
// start reports the walk finished. The wall memory is not cleared by reset.
// Stall: a result waits in the output register; the next command is taken
// meanwhile and its own result is held back until the register frees up.
`include "grid_maze_dfs_carver_top_macros.svh"

module grid_maze_dfs_carver_top #(
  parameter int unsigned GRID_WIDTH     = 256,
  parameter int unsigned GRID_HEIGHT    = 128,
  parameter int unsigned DRAWS_PER_STEP = 5
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  gmdc_in_if.sink                        in_i,
  gmdc_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gmdc_pkg::PADDR_W-1:0]   paddr,
  input  logic [gmdc_pkg::PDATA_W-1:0]   pwdata,
  output logic [gmdc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import gmdc_pkg::*;

  localparam int unsigned XW         = $clog2(GRID_WIDTH);
  localparam int unsigned YW         = $clog2(GRID_HEIGHT);
  localparam int unsigned AW         = XW + YW;
  localparam int unsigned CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned STACK_CAP  = (CELL_COUNT < 65535) ? CELL_COUNT : 65535;
  localparam int unsigned SW         = $clog2(STACK_CAP);
  localparam int unsigned DW         = $clog2(STACK_CAP + 1);
  localparam int unsigned DRAW_W     = 2 * DRAWS_PER_STEP;

  // Probe slots: four neighbors, then the top cell, then a settle slot
  localparam logic [2:0] PROBE_TOP  = 3'd4;
  localparam logic [2:0] PROBE_LAST = 3'd5;

  state_e state_q, state_d;

  logic [DW-1:0]         depth_q, depth_d;
  logic [2:0]            probe_q, probe_d;
  logic [XW-1:0]         sw_x_q, sw_x_d;
  logic [YW-1:0]         sw_y_q, sw_y_d;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_res_q, out_res_d;
  res_t                  pend_q, pend_d;
  logic [LAST_COL_W-1:0] last_column_q, last_column_d;
  logic [LAST_ROW_W-1:0] last_row_q, last_row_d;
  logic                  rd_pend_q;
  logic [2:0]            rd_tag_q;
  logic                  rd_ok_q;

  logic [DRAW_W-1:0]     draws_q;
  logic [AW-1:0]         stack_rd_q;
  logic [WALL_W-1:0]     wall_rd_q;
  logic [WALL_W-1:0]     top_wall_q;
  logic [3:0]            intact_q;
  logic [DIR_W-1:0]      hit_q;

  // Memories
  logic [WALL_W-1:0] wall_mem [2**AW];
  logic [AW-1:0]     stack_mem [STACK_CAP];

  logic              wall_we, wall_re;
  logic [AW-1:0]     wall_waddr, wall_raddr;
  logic [WALL_W-1:0] wall_wdata;
  logic              stk_we, stk_re;
  logic [SW-1:0]     stk_waddr, stk_raddr;
  logic [AW-1:0]     stk_wdata;

  logic              in_fire, out_free, cfg_wr;
  logic              sweep_last, sweep_inner;
  logic [XW-1:0]     top_x, nb_x;
  logic [YW-1:0]     top_y, nb_y;
  logic [DIR_W-1:0]  nb_dir;
  logic              nb_ok;
  logic              room, hit_found;
  logic [DIR_W-1:0]  hit_sel;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign cfg_wr   = psel && penable && pwrite;

  assign top_x = stack_rd_q[XW-1:0];
  assign top_y = stack_rd_q[AW-1:XW];

  assign sweep_last = (sw_x_q == XW'(GRID_WIDTH - 1)) && (sw_y_q == YW'(GRID_HEIGHT - 1));
  assign sweep_inner = (16'(sw_x_q) >= 16'd1) && (16'(sw_x_q) < 16'(last_column_q)) &&
                       (16'(sw_y_q) >= 16'd1) && (16'(sw_y_q) < 16'(last_row_q));

  assign room = depth_q < DW'(STACK_CAP);

  // Neighbor unit: shared by probing and by the neighbor write
  always_comb begin
    nb_dir = (state_q == ST_PROBE) ? probe_q[1:0] : hit_q;
    nb_x   = top_x;
    nb_y   = top_y;
    nb_ok  = 1'b0;
    unique case (nb_dir)
      DIR_UP: begin
        nb_y  = top_y - YW'(1);
        nb_ok = top_y != '0;
      end
      DIR_RIGHT: begin
        nb_x  = top_x + XW'(1);
        nb_ok = top_x != XW'(GRID_WIDTH - 1);
      end
      DIR_DOWN: begin
        nb_y  = top_y + YW'(1);
        nb_ok = top_y != YW'(GRID_HEIGHT - 1);
      end
      DIR_LEFT: begin
        nb_x  = top_x - XW'(1);
        nb_ok = top_x != '0;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  // Pick the first intact neighbor: draws in order, then directions 0 to 3; none if the stack is full
  always_comb begin
    hit_found = 1'b0;
    hit_sel   = DIR_UP;
    for (int k = 3; k >= 0; k--) begin
      if (intact_q[k]) begin
        hit_found = 1'b1;
        hit_sel   = DIR_W'(k);
      end
    end
    for (int k = DRAWS_PER_STEP - 1; k >= 0; k--) begin
      if (intact_q[draws_q[2*k +: 2]]) begin
        hit_found = 1'b1;
        hit_sel   = draws_q[2*k +: 2];
      end
    end
    if (!room) begin
      hit_found = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.cmd == CMD_START) begin
            state_d = ST_SWEEP;
          end else if (depth_q == '0) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_PROBE;
          end
        end
      end
      ST_SWEEP: begin
        if (sweep_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_PROBE: begin
        if (probe_q == PROBE_LAST) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: state_d = hit_found ? ST_WR_NB : ST_EMIT;
      ST_WR_NB:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    depth_d       = depth_q;
    probe_d       = probe_q;
    sw_x_d        = sw_x_q;
    sw_y_d        = sw_y_q;
    pend_d        = pend_q;
    out_valid_d   = out_valid_q;
    out_res_d     = out_res_q;
    last_column_d = last_column_q;
    last_row_d    = last_row_q;
    wall_we       = 1'b0;
    wall_waddr    = {nb_y, nb_x};
    wall_wdata    = WALL_NONE;
    wall_re       = 1'b0;
    wall_raddr    = (probe_q == PROBE_TOP) ? {top_y, top_x} : {nb_y, nb_x};
    stk_we        = 1'b0;
    stk_waddr     = depth_q[SW-1:0];
    stk_wdata     = {nb_y, nb_x};
    stk_re        = 1'b0;
    stk_raddr     = SW'(depth_q - DW'(1));

    // Drop the result word once taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    // Register writes
    if (cfg_wr) begin
      if (paddr[2] == REG_LAST_COLUMN) begin
        last_column_d = pwdata[LAST_COL_W-1:0];
      end else begin
        last_row_d = pwdata[LAST_ROW_W-1:0];
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          sw_x_d  = '0;
          sw_y_d  = '0;
          probe_d = '0;
          stk_re  = (in_i.cmd == CMD_STEP);
          pend_d  = '{event_res: EV_DONE, cell_x: '0, cell_y: '0, entry_dir: DIR_UP,
                      depth: '0};
        end
      end
      ST_SWEEP: begin
        wall_we    = 1'b1;
        wall_waddr = {sw_y_q, sw_x_q};
        wall_wdata = sweep_inner ? WALL_ALL : WALL_NONE;
        if (sw_x_q == XW'(GRID_WIDTH - 1)) begin
          sw_x_d = '0;
          sw_y_d = sw_y_q + YW'(1);
        end else begin
          sw_x_d = sw_x_q + XW'(1);
        end
        // Push the start cell as the last cell is written
        if (sweep_last) begin
          stk_we    = 1'b1;
          stk_waddr = '0;
          stk_wdata = {YW'(1), XW'(1)};
          depth_d   = DW'(1);
          pend_d    = '{event_res: EV_ENTER, cell_x: CELL_X_W'(1), cell_y: CELL_Y_W'(1),
                        entry_dir: DIR_DOWN, depth: '0};
        end
      end
      ST_PROBE: begin
        wall_re = (probe_q != PROBE_LAST);
        probe_d = probe_q + 3'd1;
      end
      ST_DECIDE: begin
        if (hit_found) begin
          wall_we    = 1'b1;
          wall_waddr = {top_y, top_x};
          wall_wdata = top_wall_q & ~(WALL_W'(1) << hit_sel);
        end else begin
          depth_d = depth_q - DW'(1);
          pend_d  = '{event_res: EV_BACK, cell_x: CELL_X_W'(top_x), cell_y: CELL_Y_W'(top_y),
                      entry_dir: DIR_UP, depth: DEPTH_W'(depth_q - DW'(1))};
        end
      end
      ST_WR_NB: begin
        wall_we    = 1'b1;
        wall_wdata = WALL_ALL & ~(WALL_W'(1) << (hit_q ^ DIR_FLIP));
        stk_we     = 1'b1;
        depth_d    = depth_q + DW'(1);
        pend_d     = '{event_res: EV_ENTER, cell_x: CELL_X_W'(nb_x), cell_y: CELL_Y_W'(nb_y),
                       entry_dir: hit_q, depth: DEPTH_W'(depth_q)};
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = pend_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      depth_q       <= '0;
      probe_q       <= '0;
      out_valid_q   <= 1'b0;
      last_column_q <= LAST_COL_RST;
      last_row_q    <= LAST_ROW_RST;
      rd_pend_q     <= 1'b0;
      rd_tag_q      <= '0;
      rd_ok_q       <= 1'b0;
    end else begin
      state_q       <= state_d;
      depth_q       <= depth_d;
      probe_q       <= probe_d;
      out_valid_q   <= out_valid_d;
      last_column_q <= last_column_d;
      last_row_q    <= last_row_d;
      rd_pend_q     <= wall_re;
      rd_tag_q      <= probe_q;
      rd_ok_q       <= nb_ok;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sw_x_q    <= sw_x_d;
    sw_y_q    <= sw_y_d;
    pend_q    <= pend_d;
    out_res_q <= out_res_d;
    if (in_fire) begin
      draws_q <= in_i.random_draws;
    end
    if (state_q == ST_DECIDE) begin
      hit_q <= hit_sel;
    end
    // Capture each probe result from the registered wall read data
    if (rd_pend_q) begin
      if (rd_tag_q == PROBE_TOP) begin
        top_wall_q <= wall_rd_q;
      end else begin
        intact_q[rd_tag_q[1:0]] <= rd_ok_q && (wall_rd_q == WALL_ALL);
      end
    end
  end

  // Wall memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wall_we) begin
      wall_mem[wall_waddr] <= wall_wdata;
    end
    if (wall_re) begin
      wall_rd_q <= wall_mem[wall_raddr];
    end
  end

  // Path stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stack_rd_q <= stack_mem[stk_raddr];
    end
  end

  // Ports
  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = out_res_q.event_res;
  assign out_o.cell_x    = out_res_q.cell_x;
  assign out_o.cell_y    = out_res_q.cell_y;
  assign out_o.entry_dir = out_res_q.entry_dir;
  assign out_o.depth     = out_res_q.depth;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_LAST_COLUMN: prdata = PDATA_W'(last_column_q);
      REG_LAST_ROW:    prdata = PDATA_W'(last_row_q);
      default:         prdata = '0;
    endcase
  end

  // Checks
  `GMDC_ASSERT_ALWAYS(a_depth_cap, depth_q <= DW'(STACK_CAP), "stack depth beyond capacity")
  `GMDC_ASSERT(a_push_depth, state_q == ST_WR_NB |=> depth_q == $past(depth_q) + DW'(1), "push did not grow the stack")
  `GMDC_ASSERT(a_start_sweep, (in_fire && in_i.cmd == CMD_START) |=> state_q == ST_SWEEP, "start did not begin the sweep")
  `GMDC_ASSERT(a_emit_src, $rose(out_valid_q) |-> $past(state_q) == ST_EMIT, "result word loaded outside emit")

endmodule
